/* rtl/photon_pair_mass_and_approach_unit_macros.svh */
// assertion macros used by ppma_back
`ifndef PHOTON_PAIR_MASS_AND_APPROACH_UNIT_MACROS_SVH
`define PHOTON_PAIR_MASS_AND_APPROACH_UNIT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define PPMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising clk edge, reset included
`define PPMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ppma_pkg.sv */
package ppma_pkg;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  localparam int DVW = 51;
  localparam int DQW = 18;

  localparam logic [20:0] MASS_MAX = 21'h1FFFFF;
  localparam logic [15:0] DIST_MAX = 16'hFFFF;

  localparam logic [2:0] REG_BOX_X_LOW  = 3'd0;
  localparam logic [2:0] REG_BOX_X_HIGH = 3'd1;
  localparam logic [2:0] REG_BOX_Y_LOW  = 3'd2;
  localparam logic [2:0] REG_BOX_Y_HIGH = 3'd3;
  localparam logic [2:0] REG_BOX_Z_LOW  = 3'd4;
  localparam logic [2:0] REG_BOX_Z_HIGH = 3'd5;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] sz;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] dz;
    logic [19:0] energy;
    logic [15:0] len;
  } shower_t;

  typedef struct packed {
    shower_t a;
    shower_t b;
  } pair_t;

  typedef struct packed {
    logic [15:0] xl;
    logic [15:0] xh;
    logic [15:0] yl;
    logic [15:0] yh;
    logic [15:0] zl;
    logic [15:0] zh;
  } box_t;

  typedef struct packed {
    logic [20:0] mass;
    logic [15:0] approach;
    logic [1:0]  cnt;
    logic        degen;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic           start;
    logic [DVW-1:0] dividend;
    logic [31:0]    divisor;
  } div_req_t;

  function automatic logic signed [33:0] sx34(input logic [15:0] v);
    return $signed({{18{v[15]}}, v});
  endfunction

  function automatic logic signed [16:0] sx17(input logic [15:0] v);
    return $signed({v[15], v});
  endfunction

endpackage

/* rtl/ppma_queue.sv */
module ppma_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  ppma_pkg::pair_t   wr_data,
  output logic              full,
  input  logic              rd_en,
  output ppma_pkg::pair_t   rd_data,
  output logic              empty
);

  ppma_pkg::pair_t         mem_r [ppma_pkg::QDEPTH];
  logic [ppma_pkg::QAW-1:0] wp_r;
  logic [ppma_pkg::QAW-1:0] rp_r;
  logic [ppma_pkg::QAW:0]   cnt_r;

  assign full    = (cnt_r == (ppma_pkg::QAW+1)'(ppma_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en && !full) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd_en && !empty) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (ppma_pkg::QAW+1)'(wr_en && !full)
                     - (ppma_pkg::QAW+1)'(rd_en && !empty);
    end
  end

endmodule

/* rtl/ppma_front.sv */
module ppma_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              mode,
  input  ppma_pkg::shower_t shower,
  input  logic              q_full,
  output logic              q_wr,
  output ppma_pkg::pair_t   q_data
);

  ppma_pkg::shower_t held_r;
  logic              held_valid_r;
  logic              acc;

  assign acc    = push && !q_full;
  assign q_wr   = acc && mode && held_valid_r;
  assign q_data = '{a: held_r, b: shower};

  always_ff @(posedge clk) begin
    if (acc && !mode) begin
      held_r <= shower;
    end
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else if (acc && !mode) begin
      held_valid_r <= 1'b1;
    end else if (q_wr) begin
      held_valid_r <= 1'b0;
    end
  end

endmodule

/* rtl/ppma_isqrt.sv */
module ppma_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  ppma_pkg::sqrt_req_t req,
  output logic                busy,
  output logic [31:0]         root
);

  logic [63:0] v_r;
  logic [63:0] r_r;
  logic [63:0] bit_r;
  logic [64:0] trial;

  assign trial = {1'b0, r_r} + {1'b0, bit_r};
  assign busy  = (bit_r != '0);
  assign root  = r_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (req.start) begin
      v_r   <= req.radicand;
      r_r   <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if ({1'b0, v_r} >= trial) begin
        v_r <= v_r - trial[63:0];
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

/* rtl/ppma_div.sv */
module ppma_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ppma_pkg::div_req_t             req,
  output logic                           busy,
  output logic [ppma_pkg::DQW-1:0]       quo
);

  logic [ppma_pkg::DVW-1:0] rem_r;
  logic [ppma_pkg::DVW-1:0] dsh_r;
  logic [ppma_pkg::DQW-1:0] quo_r;
  logic [4:0]               cnt_r;

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      rem_r <= req.dividend;
      dsh_r <= ppma_pkg::DVW'({req.divisor, (ppma_pkg::DQW-1)'(0)});
      quo_r <= '0;
      cnt_r <= 5'(ppma_pkg::DQW);
    end else if (busy) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        quo_r <= {quo_r[ppma_pkg::DQW-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[ppma_pkg::DQW-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r - 5'd1;
    end
  end

endmodule

/* rtl/ppma_back.sv */
`include "photon_pair_mass_and_approach_unit_macros.svh"

module ppma_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ppma_pkg::pair_t   pair,
  input  logic              q_empty,
  output logic              q_pop,
  input  ppma_pkg::box_t    box,
  output logic              res_valid,
  output ppma_pkg::result_t res,
  input  logic              res_pop
);

  typedef enum logic [3:0] {
    B_IDLE, B_MUL, B_SQ_S, B_DIV_Q, B_MQ0, B_MQ1, B_MQ2,
    B_SQ_M, B_SQ_N, B_DIV_D, B_DONE
  } bstate_t;

  bstate_t           state_r;
  logic [5:0]        pc_r;
  logic              issued_r;
  ppma_pkg::pair_t   p_r_pair;
  logic signed [67:0] p_r;
  logic signed [33:0] ma;
  logic signed [33:0] mb;

  logic [31:0]        n1_r;
  logic [31:0]        n2_r;
  logic signed [33:0] dot_r;
  logic signed [33:0] nv0_r;
  logic signed [33:0] nv1_r;
  logic signed [33:0] nv2_r;
  logic [63:0]        prod_r;
  logic [63:0]        nsq_r;
  logic signed [49:0] t_r;
  logic [39:0]        x_r;
  logic [17:0]        q_r;
  logic [37:0]        lo_r;
  logic [44:0]        m2_r;
  logic [31:0]        s_r;
  logic [31:0]        rt_r;
  logic [20:0]        mass_r;
  logic [15:0]        dist_r;
  logic               c1_r;
  logic               c2_r;
  logic               pre_r;
  logic [30:0]        numsh_r;

  logic               zero_dir;
  logic               par;
  logic [49:0]        abs_t;
  logic signed [34:0] numq;
  logic [59:0]        msum;

  // face check operands
  logic [5:0]         fsub;
  logic [3:0]         fidx;
  logic [3:0]         fax;
  logic               fsh;
  logic [15:0]        face;
  logic [15:0]        fst;
  logic [15:0]        fdir;
  logic [15:0]        flen;
  logic signed [16:0] fnum;
  logic [16:0]        fabsnum;
  logic [16:0]        fabsden;
  logic               fpre;
  logic               crossed;

  ppma_pkg::sqrt_req_t sq_req;
  ppma_pkg::div_req_t  dv_req;
  logic                sq_busy;
  logic                dv_busy;
  logic [31:0]         sq_root;
  logic [17:0]         dv_quo;

  ppma_isqrt u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sq_req),
    .busy (sq_busy),
    .root (sq_root)
  );

  ppma_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dv_req),
    .busy (dv_busy),
    .quo  (dv_quo)
  );

  assign zero_dir = (n1_r == '0) || (n2_r == '0);
  assign par      = (nsq_r == '0);
  assign abs_t    = t_r[49] ? 50'(-t_r) : 50'(t_r);
  assign numq     = $signed({3'b000, s_r}) - $signed({dot_r[33], dot_r});
  assign msum     = ({22'd0, p_r[37:0]} << 20) + {22'd0, lo_r};

  assign q_pop        = (state_r == B_IDLE) && !q_empty;
  assign res_valid    = (state_r == B_DONE);
  assign res.mass     = mass_r;
  assign res.approach = dist_r;
  assign res.cnt      = 2'(c1_r) + 2'(c2_r);
  assign res.degen    = zero_dir || par;

  always_comb begin
    fsub = pc_r - 6'd23;
    fidx = fsub[3:0];
    fsh  = (fidx >= 4'd6);
    fax  = fsh ? fidx - 4'd6 : fidx;
    flen = fsh ? p_r_pair.b.len : p_r_pair.a.len;
    case (fax[2:1])
      2'd0: begin
        face = fidx[0] ? box.xh : box.xl;
        fst  = fsh ? p_r_pair.b.sx : p_r_pair.a.sx;
        fdir = fsh ? p_r_pair.b.dx : p_r_pair.a.dx;
      end
      2'd1: begin
        face = fidx[0] ? box.yh : box.yl;
        fst  = fsh ? p_r_pair.b.sy : p_r_pair.a.sy;
        fdir = fsh ? p_r_pair.b.dy : p_r_pair.a.dy;
      end
      default: begin
        face = fidx[0] ? box.zh : box.zl;
        fst  = fsh ? p_r_pair.b.sz : p_r_pair.a.sz;
        fdir = fsh ? p_r_pair.b.dz : p_r_pair.a.dz;
      end
    endcase
    fnum    = ppma_pkg::sx17(face) - ppma_pkg::sx17(fst);
    fabsnum = fnum[16] ? 17'(-fnum) : 17'(fnum);
    fabsden = fdir[15] ? 17'(-ppma_pkg::sx17(fdir)) : {1'b0, fdir};
    fpre    = (fnum != '0) && (fdir != '0) && (fnum[16] == fdir[15]);
    crossed = pre_r && ({1'b0, numsh_r} < p_r[31:0]);
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      B_MUL: begin
        case (pc_r)
          6'd0:  begin ma = ppma_pkg::sx34(p_r_pair.a.dx); mb = ma; end
          6'd1:  begin ma = ppma_pkg::sx34(p_r_pair.a.dy); mb = ma; end
          6'd2:  begin ma = ppma_pkg::sx34(p_r_pair.a.dz); mb = ma; end
          6'd3:  begin ma = ppma_pkg::sx34(p_r_pair.b.dx); mb = ma; end
          6'd4:  begin ma = ppma_pkg::sx34(p_r_pair.b.dy); mb = ma; end
          6'd5:  begin ma = ppma_pkg::sx34(p_r_pair.b.dz); mb = ma; end
          6'd6:  begin
            ma = ppma_pkg::sx34(p_r_pair.a.dx); mb = ppma_pkg::sx34(p_r_pair.b.dx);
          end
          6'd7:  begin
            ma = ppma_pkg::sx34(p_r_pair.a.dy); mb = ppma_pkg::sx34(p_r_pair.b.dy);
          end
          6'd8:  begin
            ma = ppma_pkg::sx34(p_r_pair.a.dz); mb = ppma_pkg::sx34(p_r_pair.b.dz);
          end
          6'd9:  begin
            ma = ppma_pkg::sx34(p_r_pair.a.dy); mb = ppma_pkg::sx34(p_r_pair.b.dz);
          end
          6'd10: begin
            ma = ppma_pkg::sx34(p_r_pair.a.dz); mb = ppma_pkg::sx34(p_r_pair.b.dy);
          end
          6'd11: begin
            ma = ppma_pkg::sx34(p_r_pair.a.dz); mb = ppma_pkg::sx34(p_r_pair.b.dx);
          end
          6'd12: begin
            ma = ppma_pkg::sx34(p_r_pair.a.dx); mb = ppma_pkg::sx34(p_r_pair.b.dz);
          end
          6'd13: begin
            ma = ppma_pkg::sx34(p_r_pair.a.dx); mb = ppma_pkg::sx34(p_r_pair.b.dy);
          end
          6'd14: begin
            ma = ppma_pkg::sx34(p_r_pair.a.dy); mb = ppma_pkg::sx34(p_r_pair.b.dx);
          end
          6'd15: begin ma = $signed({2'b00, n1_r}); mb = $signed({2'b00, n2_r}); end
          6'd16: begin ma = nv0_r; mb = nv0_r; end
          6'd17: begin ma = nv1_r; mb = nv1_r; end
          6'd18: begin ma = nv2_r; mb = nv2_r; end
          6'd19: begin
            ma = 34'(ppma_pkg::sx17(p_r_pair.a.sx) - ppma_pkg::sx17(p_r_pair.b.sx));
            mb = nv0_r;
          end
          6'd20: begin
            ma = 34'(ppma_pkg::sx17(p_r_pair.a.sy) - ppma_pkg::sx17(p_r_pair.b.sy));
            mb = nv1_r;
          end
          6'd21: begin
            ma = 34'(ppma_pkg::sx17(p_r_pair.a.sz) - ppma_pkg::sx17(p_r_pair.b.sz));
            mb = nv2_r;
          end
          6'd22: begin
            ma = $signed({14'd0, p_r_pair.a.energy});
            mb = $signed({14'd0, p_r_pair.b.energy});
          end
          default: begin
            ma = $signed({18'd0, flen});
            mb = $signed({17'd0, fabsden});
          end
        endcase
      end
      B_MQ0: begin ma = $signed({14'd0, x_r[19:0]}); mb = $signed({16'd0, q_r}); end
      B_MQ1: begin ma = $signed({14'd0, x_r[39:20]}); mb = $signed({16'd0, q_r}); end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    sq_req = '0;
    dv_req = '0;
    unique case (state_r)
      B_SQ_S: begin
        sq_req.start    = !issued_r && !zero_dir;
        sq_req.radicand = prod_r;
      end
      B_SQ_M: begin
        sq_req.start    = !issued_r;
        sq_req.radicand = {19'd0, m2_r};
      end
      B_SQ_N: begin
        sq_req.start    = !issued_r && !par;
        sq_req.radicand = nsq_r;
      end
      B_DIV_Q: begin
        dv_req.start    = !issued_r;
        dv_req.dividend = {1'b0, numq[33:0], 16'd0};
        dv_req.divisor  = s_r;
      end
      B_DIV_D: begin
        dv_req.start    = !issued_r;
        dv_req.dividend = {1'b0, abs_t};
        dv_req.divisor  = rt_r;
      end
      default: begin
        sq_req = '0;
        dv_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= ma * mb;
    if (!rst_n) begin
      state_r  <= B_IDLE;
      pc_r     <= '0;
      issued_r <= 1'b0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            p_r_pair <= pair;
            pc_r     <= '0;
            c1_r     <= 1'b1;
            c2_r     <= 1'b1;
            state_r  <= B_MUL;
          end
        end
        B_MUL: begin
          pc_r <= pc_r + 6'd1;
          case (pc_r)
            6'd1:  n1_r <= p_r[31:0];
            6'd2, 6'd3: n1_r <= n1_r + p_r[31:0];
            6'd4:  n2_r <= p_r[31:0];
            6'd5, 6'd6: n2_r <= n2_r + p_r[31:0];
            6'd7:  dot_r <= $signed(p_r[33:0]);
            6'd8, 6'd9: dot_r <= dot_r + $signed(p_r[33:0]);
            6'd10: nv0_r <= $signed(p_r[33:0]);
            6'd11: nv0_r <= nv0_r - $signed(p_r[33:0]);
            6'd12: nv1_r <= $signed(p_r[33:0]);
            6'd13: nv1_r <= nv1_r - $signed(p_r[33:0]);
            6'd14: nv2_r <= $signed(p_r[33:0]);
            6'd15: nv2_r <= nv2_r - $signed(p_r[33:0]);
            6'd16: prod_r <= p_r[63:0];
            6'd17: nsq_r <= p_r[63:0];
            6'd18, 6'd19: nsq_r <= nsq_r + p_r[63:0];
            6'd20: t_r <= $signed(p_r[49:0]);
            6'd21, 6'd22: t_r <= t_r + $signed(p_r[49:0]);
            6'd23: x_r <= p_r[39:0];
            default: begin
              if (pc_r >= 6'd24 && crossed) begin
                if (pc_r >= 6'd30) begin
                  c2_r <= 1'b0;
                end else begin
                  c1_r <= 1'b0;
                end
              end
            end
          endcase
          pre_r   <= fpre;
          numsh_r <= {fabsnum[16:0], 14'd0};
          if (pc_r == 6'd35) begin
            state_r <= B_SQ_S;
          end
        end
        B_SQ_S: begin
          if (!issued_r) begin
            if (zero_dir) begin
              mass_r  <= '0;
              state_r <= B_SQ_N;
            end else begin
              issued_r <= 1'b1;
            end
          end else if (!sq_busy) begin
            issued_r <= 1'b0;
            s_r      <= sq_root;
            state_r  <= B_DIV_Q;
          end
        end
        B_DIV_Q: begin
          if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (!dv_busy) begin
            issued_r <= 1'b0;
            q_r      <= dv_quo;
            state_r  <= B_MQ0;
          end
        end
        B_MQ0: state_r <= B_MQ1;
        B_MQ1: begin
          lo_r    <= p_r[37:0];
          state_r <= B_MQ2;
        end
        B_MQ2: begin
          m2_r    <= msum[59:15];
          state_r <= B_SQ_M;
        end
        B_SQ_M: begin
          if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (!sq_busy) begin
            issued_r <= 1'b0;
            mass_r   <= (sq_root > 32'(ppma_pkg::MASS_MAX)) ? ppma_pkg::MASS_MAX
                                                           : sq_root[20:0];
            state_r  <= B_SQ_N;
          end
        end
        B_SQ_N: begin
          if (!issued_r) begin
            if (par) begin
              dist_r  <= ppma_pkg::DIST_MAX;
              state_r <= B_DONE;
            end else begin
              issued_r <= 1'b1;
            end
          end else if (!sq_busy) begin
            issued_r <= 1'b0;
            rt_r     <= sq_root;
            if (abs_t >= {2'b00, sq_root, 16'd0}) begin
              dist_r  <= ppma_pkg::DIST_MAX;
              state_r <= B_DONE;
            end else begin
              state_r <= B_DIV_D;
            end
          end
        end
        B_DIV_D: begin
          if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (!dv_busy) begin
            issued_r <= 1'b0;
            dist_r   <= dv_quo[15:0];
            state_r  <= B_DONE;
          end
        end
        B_DONE: begin
          if (res_pop) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  `PPMA_ASSERT(a_sqrt_free, sq_req.start |-> !sq_busy, "isqrt started while busy")
  `PPMA_ASSERT(a_div_free, dv_req.start |-> !dv_busy, "divider started while busy")
  `PPMA_ASSERT(a_res_hold, (res_valid && !res_pop) |=> (res_valid && $stable(res)), "result changed before pop")

endmodule

/* rtl/photon_pair_mass_and_approach_unit.sv */
// the back end takes one pair at a time and runs the shared isqrt (three uses)
// and the divider (two uses); a 2-entry pair queue lets the input keep taking
// showers while the back end works or a result waits for pop
// reset: synchronous active-low rst_n clears the held shower, queue and sequencer,
// and loads the box registers with their default faces
module photon_pair_mass_and_approach_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_mode,
  input  logic [15:0] in_start_x,
  input  logic [15:0] in_start_y,
  input  logic [15:0] in_start_z,
  input  logic [15:0] in_dir_x,
  input  logic [15:0] in_dir_y,
  input  logic [15:0] in_dir_z,
  input  logic [19:0] in_energy,
  input  logic [15:0] in_shower_length,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [20:0] out_pair_mass,
  output logic [15:0] out_approach_distance,
  output logic [1:0]  out_contained_count,
  output logic        out_degenerate,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ppma_pkg::box_t    box_r;
  ppma_pkg::shower_t shower;
  ppma_pkg::pair_t   wr_pair;
  ppma_pkg::pair_t   rd_pair;
  ppma_pkg::result_t res;
  logic              q_full;
  logic              q_wr;
  logic              q_empty;
  logic              q_pop;
  logic              res_valid;

  assign shower = '{sx: in_start_x, sy: in_start_y, sz: in_start_z,
                    dx: in_dir_x, dy: in_dir_y, dz: in_dir_z,
                    energy: in_energy, len: in_shower_length};

  assign in_full   = q_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r.xl <= 16'd0;
      box_r.xh <= 16'd4096;
      box_r.yl <= 16'hF8D0;
      box_r.yh <= 16'd1840;
      box_r.zl <= 16'd0;
      box_r.zh <= 16'd16576;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppma_pkg::REG_BOX_X_LOW:  box_r.xl <= cfg_data;
        ppma_pkg::REG_BOX_X_HIGH: box_r.xh <= cfg_data;
        ppma_pkg::REG_BOX_Y_LOW:  box_r.yl <= cfg_data;
        ppma_pkg::REG_BOX_Y_HIGH: box_r.yh <= cfg_data;
        ppma_pkg::REG_BOX_Z_LOW:  box_r.zl <= cfg_data;
        ppma_pkg::REG_BOX_Z_HIGH: box_r.zh <= cfg_data;
        default: ;
      endcase
    end
  end

  ppma_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .mode  (in_mode),
    .shower(shower),
    .q_full(q_full),
    .q_wr  (q_wr),
    .q_data(wr_pair)
  );

  ppma_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_wr),
    .wr_data(wr_pair),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(rd_pair),
    .empty  (q_empty)
  );

  ppma_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pair     (rd_pair),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .box      (box_r),
    .res_valid(res_valid),
    .res      (res),
    .res_pop  (out_pop)
  );

  assign out_empty             = !res_valid;
  assign out_pair_mass         = res.mass;
  assign out_approach_distance = res.approach;
  assign out_contained_count   = res.cnt;
  assign out_degenerate        = res.degen;

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit                mode;
    ppma_pkg::shower_t sh;
  } shower_item_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_push = 0;
  logic        in_full;
  logic        in_mode = 0;
  logic [15:0] in_start_x = 0, in_start_y = 0, in_start_z = 0;
  logic [15:0] in_dir_x = 0, in_dir_y = 0, in_dir_z = 0;
  logic [19:0] in_energy = 0;
  logic [15:0] in_shower_length = 0;
  logic        out_empty;
  logic        out_pop = 0;
  logic [20:0] out_pair_mass;
  logic [15:0] out_approach_distance;
  logic [1:0]  out_contained_count;
  logic        out_degenerate;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;

  photon_pair_mass_and_approach_unit u_dut (.*);

  shower_item_t      pending_showers[$];
  ppma_pkg::result_t expected_pairs[$];
  shower_item_t      cur;
  bit                have_cur = 0;
  int                idle_in = 0, idle_out = 0;
  bit                calm = 0;
  logic              hold_off = 0;
  int                errors = 0;

  // predictor state
  logic [15:0]       box_lo[3], box_hi[3];
  bit                held_ok;
  ppma_pkg::shower_t held;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(input longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic bit face_crossed(input longint face, input longint st, input longint dir,
                                      input longint unsigned len);
    longint num;
    num = face - st;
    if (num == 0 || dir == 0) return 0;
    if ((num > 0) != (dir > 0)) return 0;
    return mag(num) * 16384 < len * mag(dir);
  endfunction

  function automatic bit shower_inside(input ppma_pkg::shower_t sh);
    longint st[3], dr[3];
    st[0] = $signed(sh.sx); st[1] = $signed(sh.sy); st[2] = $signed(sh.sz);
    dr[0] = $signed(sh.dx); dr[1] = $signed(sh.dy); dr[2] = $signed(sh.dz);
    for (int k = 0; k < 3; k++) begin
      if (face_crossed($signed(box_lo[k]), st[k], dr[k], sh.len)) return 0;
      if (face_crossed($signed(box_hi[k]), st[k], dr[k], sh.len)) return 0;
    end
    return 1;
  endfunction

  function automatic bit pair_predict(input shower_item_t it, output ppma_pkg::result_t r);
    longint d1[3], d2[3], nv[3], w[3], dot, t;
    longint unsigned n1, n2, s, num, q, m2, mass, appr, nn;
    bit zero_dir;
    r = '0;
    if (!it.mode) begin
      held = it.sh;
      held_ok = 1;
      return 0;
    end
    if (!held_ok) return 0;
    held_ok = 0;
    d1[0] = $signed(held.dx); d1[1] = $signed(held.dy); d1[2] = $signed(held.dz);
    d2[0] = $signed(it.sh.dx); d2[1] = $signed(it.sh.dy); d2[2] = $signed(it.sh.dz);
    w[0] = longint'($signed(held.sx)) - longint'($signed(it.sh.sx));
    w[1] = longint'($signed(held.sy)) - longint'($signed(it.sh.sy));
    w[2] = longint'($signed(held.sz)) - longint'($signed(it.sh.sz));
    n1 = d1[0] * d1[0] + d1[1] * d1[1] + d1[2] * d1[2];
    n2 = d2[0] * d2[0] + d2[1] * d2[1] + d2[2] * d2[2];
    dot = d1[0] * d2[0] + d1[1] * d2[1] + d1[2] * d2[2];
    zero_dir = (n1 == 0 || n2 == 0);
    mass = 0;
    if (!zero_dir) begin
      s = int_sqrt(n1 * n2);
      num = dot < 0 ? s + mag(dot) : s - longint'(dot);
      q = (num << 16) / s;
      m2 = (longint'(held.energy) * longint'(it.sh.energy) * q) >> 15;
      mass = int_sqrt(m2);
      if (mass > ppma_pkg::MASS_MAX) mass = ppma_pkg::MASS_MAX;
    end
    nv[0] = d1[1] * d2[2] - d1[2] * d2[1];
    nv[1] = d1[2] * d2[0] - d1[0] * d2[2];
    nv[2] = d1[0] * d2[1] - d1[1] * d2[0];
    nn = nv[0] * nv[0] + nv[1] * nv[1] + nv[2] * nv[2];
    if (nn == 0) begin
      appr = ppma_pkg::DIST_MAX;
    end else begin
      t = w[0] * nv[0] + w[1] * nv[1] + w[2] * nv[2];
      appr = mag(t) / int_sqrt(nn);
      if (appr > ppma_pkg::DIST_MAX) appr = ppma_pkg::DIST_MAX;
    end
    r.mass = mass[20:0];
    r.approach = appr[15:0];
    r.cnt = 2'(shower_inside(held)) + 2'(shower_inside(it.sh));
    r.degen = zero_dir || nn == 0;
    return 1;
  endfunction

  // input side driver
  always @(posedge clk) begin
    ppma_pkg::result_t r;
    if (!rst_n) begin
      in_push <= 0;
    end else begin
      if (in_push && !in_full) begin
        if (pair_predict(cur, r)) expected_pairs.insert(expected_pairs.size(), r);
        have_cur = 0;
      end
      if (!have_cur && pending_showers.size() > 0) begin
        cur = pending_showers.pop_front();
        have_cur = 1;
      end
      if (idle_in > 0) idle_in--;
      else if (!calm && $urandom_range(0, 9) == 0) idle_in = int'($urandom_range(1, 5));
      in_push <= have_cur && idle_in == 0;
      in_mode <= cur.mode;
      in_start_x <= cur.sh.sx;
      in_start_y <= cur.sh.sy;
      in_start_z <= cur.sh.sz;
      in_dir_x <= cur.sh.dx;
      in_dir_y <= cur.sh.dy;
      in_dir_z <= cur.sh.dz;
      in_energy <= cur.sh.energy;
      in_shower_length <= cur.sh.len;
    end
  end

  // result side monitor
  always @(posedge clk) begin
    ppma_pkg::result_t e;
    if (!rst_n) begin
      out_pop <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t: unexpected transaction mass %0d dist %0d", $time, out_pair_mass,
                   out_approach_distance);
          errors++;
        end else begin
          e = expected_pairs.pop_front();
          if (out_pair_mass !== e.mass) begin
            $display("%0t: pair_mass expected %0d actual %0d", $time, e.mass, out_pair_mass);
            errors++;
          end
          if (out_approach_distance !== e.approach) begin
            $display("%0t: approach_distance expected %0d actual %0d", $time, e.approach,
                     out_approach_distance);
            errors++;
          end
          if (out_contained_count !== e.cnt) begin
            $display("%0t: contained_count expected %0d actual %0d", $time, e.cnt,
                     out_contained_count);
            errors++;
          end
          if (out_degenerate !== e.degen) begin
            $display("%0t: degenerate expected %0d actual %0d", $time, e.degen,
                     out_degenerate);
            errors++;
          end
        end
      end
      if (idle_out > 0) idle_out--;
      else if (!calm && $urandom_range(0, 9) == 0) idle_out = int'($urandom_range(1, 5));
      out_pop <= !hold_off && idle_out == 0;
    end
  end

  // long receiver hold-off so the input backs up
  initial begin
    repeat (300) @(posedge clk);
    hold_off <= 1;
    repeat (800) @(posedge clk);
    hold_off <= 0;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [15:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return 16'($urandom);
      default: return 16'($urandom_range(0, 20000) - 2000);
    endcase
  endfunction

  function automatic logic [15:0] pick_dir();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd16384;
      2: return -16'sd16384;
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic ppma_pkg::shower_t pick_shower();
    ppma_pkg::shower_t sh;
    sh.sx = pick_pos(); sh.sy = pick_pos(); sh.sz = pick_pos();
    sh.dx = pick_dir(); sh.dy = pick_dir(); sh.dz = pick_dir();
    case ($urandom_range(0, 5))
      0: sh.energy = 20'hFFFFF;
      1: sh.energy = 0;
      2: sh.energy = 20'($urandom);
      default: sh.energy = 20'($urandom_range(0, 20000));
    endcase
    case ($urandom_range(0, 5))
      0: sh.len = 16'hFFFF;
      1: sh.len = 0;
      2: sh.len = 16'($urandom);
      default: sh.len = 16'($urandom_range(0, 4000));
    endcase
    return sh;
  endfunction

  task automatic add_shower(input bit mode, input ppma_pkg::shower_t sh);
    shower_item_t it;
    it.mode = mode;
    it.sh = sh;
    pending_showers.insert(pending_showers.size(), it);
  endtask

  function automatic ppma_pkg::shower_t mk(input int x, y, z, dx, dy, dz, input int e, l);
    ppma_pkg::shower_t sh;
    sh.sx = 16'(x); sh.sy = 16'(y); sh.sz = 16'(z);
    sh.dx = 16'(dx); sh.dy = 16'(dy); sh.dz = 16'(dz);
    sh.energy = 20'(e); sh.len = 16'(l);
    return sh;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (pending_showers.size() != 0 || have_cur || expected_pairs.size() != 0)
      @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ppma_pkg::REG_BOX_X_LOW:  box_lo[0] = val;
      ppma_pkg::REG_BOX_X_HIGH: box_hi[0] = val;
      ppma_pkg::REG_BOX_Y_LOW:  box_lo[1] = val;
      ppma_pkg::REG_BOX_Y_HIGH: box_hi[1] = val;
      ppma_pkg::REG_BOX_Z_LOW:  box_lo[2] = val;
      ppma_pkg::REG_BOX_Z_HIGH: box_hi[2] = val;
      default: ;
    endcase
    cfg_valid <= 0;
  endtask

  task automatic write_box(input int xl, xh, yl, yh, zl, zh);
    write_reg(ppma_pkg::REG_BOX_X_LOW, 16'(xl));
    write_reg(ppma_pkg::REG_BOX_X_HIGH, 16'(xh));
    write_reg(ppma_pkg::REG_BOX_Y_LOW, 16'(yl));
    write_reg(ppma_pkg::REG_BOX_Y_HIGH, 16'(yh));
    write_reg(ppma_pkg::REG_BOX_Z_LOW, 16'(zl));
    write_reg(ppma_pkg::REG_BOX_Z_HIGH, 16'(zh));
  endtask

  task automatic random_showers(input int n);
    ppma_pkg::shower_t a, b;
    for (int i = 0; i < n; ) begin
      if ($urandom_range(0, 6) == 0) begin
        add_shower(1'($urandom_range(0, 1)), pick_shower());
        i++;
      end else begin
        a = pick_shower();
        b = pick_shower();
        case ($urandom_range(0, 7))
          0: begin b.dx = a.dx; b.dy = a.dy; b.dz = a.dz; end
          1: begin b.dx = -a.dx; b.dy = -a.dy; b.dz = -a.dz; end
          default: ;
        endcase
        add_shower(0, a);
        add_shower(1, b);
        i += 2;
      end
    end
  endtask

  initial begin
    box_lo[0] = 16'(0);     box_hi[0] = 16'(4096);
    box_lo[1] = 16'(-1840); box_hi[1] = 16'(1840);
    box_lo[2] = 16'(0);     box_hi[2] = 16'(16576);
    held_ok = 0;
    held = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: mode 1 with nothing held, then replaced held shower
    add_shower(1, mk(100, 0, 100, 16384, 0, 0, 1000, 100));
    add_shower(0, mk(5, 5, 5, 0, 16384, 0, 500, 10));
    add_shower(0, mk(2048, 0, 8000, 0, 0, 16384, 16000, 800));
    add_shower(1, mk(1000, 100, 8000, 16384, 0, 0, 16000, 800));
    // zero direction
    add_shower(0, mk(0, 0, 0, 0, 0, 0, 4000, 50));
    add_shower(1, mk(10, 10, 10, 0, 16384, 0, 4000, 50));
    // parallel lines
    add_shower(0, mk(100, 200, 300, 11585, 11585, 0, 3000, 64));
    add_shower(1, mk(-100, 20, 30, -11585, -11585, 0, 3000, 64));
    // mass just below its clamp, back to back at full energy
    add_shower(0, mk(0, 0, 0, 16384, 0, 0, 20'hFFFFF, 0));
    add_shower(1, mk(0, 0, 0, -16384, 0, 0, 20'hFFFFF, 0));
    // distance overflow at the corner extremes
    add_shower(0, mk(0, 32767, -32768, 16384, 0, 0, 0, 16'hFFFF));
    add_shower(1, mk(0, -32768, 32767, 0, 16384, 16384, 20'hFFFFF, 16'hFFFF));
    // extreme corners, full length crossing and zero components
    add_shower(0, mk(-32768, -32768, -32768, -16384, -16384, -16384, 1, 16'hFFFF));
    add_shower(1, mk(32767, 32767, 32767, 16384, -16384, 16384, 20'hFFFFF, 16'hFFFF));
    add_shower(0, mk(2000, 0, 100, 0, 0, 16384, 7777, 3000));
    add_shower(1, mk(2000, 1000, 20000, 0, 16384, -16384, 1234, 100));
    wait_idle();
    random_showers(140);
    wait_idle();
    write_box(-32768, 32767, -32768, 32767, -32768, 32767);
    random_showers(140);
    wait_idle();
    // inverted box
    write_box(4096, 0, 1840, -1840, 16576, 0);
    random_showers(140);
    wait_idle();
    write_box(32767, -32768, 32767, -32768, 32767, -32768);
    random_showers(134);
    wait_idle();
    write_box($urandom_range(0, 3000) - 1500, $urandom_range(2000, 9000),
              $urandom_range(0, 3000) - 3000, $urandom_range(0, 3000),
              $urandom_range(0, 2000) - 1000, $urandom_range(4000, 20000));
    random_showers(120);
    @(negedge clk);
    while (pending_showers.size() > 60) @(negedge clk);
    calm = 1;
    random_showers(60);
    wait_idle();
    if (errors == 0 && expected_pairs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/ppma_pkg.sv
rtl/ppma_queue.sv
rtl/ppma_front.sv
rtl/ppma_isqrt.sv
rtl/ppma_div.sv
rtl/ppma_back.sv
rtl/photon_pair_mass_and_approach_unit.sv
verif/tb_top.sv
